### sv/integer_to_ascii_digits_unit_defines.svh
// Assertion helpers; the enclosing module supplies i_clk and i_rst_n.
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_DEFINES_SVH

// same-cycle implication
`define ITAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itad assertion failed");

// next-cycle implication
`define ITAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itad assertion failed");

`endif

### sv/itad_pkg.sv
`default_nettype none

package itad_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int MAX_CHARS  = 11;

    // decimal digits of 2^(DATA_WIDTH-1), hex digits of a full word
    localparam int DEC_DIGITS = (DATA_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (DATA_WIDTH + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int DIG_BITS   = 4 * NUM_DIGITS;
    localparam int REM_MAX    = (NUM_DIGITS > MAX_CHARS) ? NUM_DIGITS : MAX_CHARS;
    localparam int REM_W      = $clog2(REM_MAX + 1);
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h57;
    localparam logic [6:0] CH_MINUS = 7'h2d;

    localparam logic ACT_DEC = 1'b0;
    localparam logic ACT_HEX = 1'b1;

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [DIG_BITS-1:0]   t_digits;

    typedef struct packed {
        logic    done;
        logic    neg;
        t_digits digs;
    } t_conv;

endpackage

`default_nettype wire

### sv/itad_dabble.sv
`default_nettype none

module itad_dabble (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire               i_action,
    input  itad_pkg::t_word   i_value,
    output logic              o_busy,
    output itad_pkg::t_conv   o_conv
);
    import itad_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_CONV
    } t_state;

    t_state             r_state;
    logic               r_done;
    logic               r_neg;
    t_word              r_mag;
    t_digits            r_digs;
    logic [CNT_W-1:0]   r_cnt;
    t_digits            n_adj;

    // add-3 correction on every BCD digit before the shift
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_digs[4*k +: 4] >= 4'd5) begin
                n_adj[4*k +: 4] = r_digs[4*k +: 4] + 4'd3;
            end else begin
                n_adj[4*k +: 4] = r_digs[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_neg   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_action == ACT_HEX) begin
                            r_digs <= DIG_BITS'(i_value);
                            r_neg  <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_digs  <= '0;
                            r_neg   <= i_value[DATA_WIDTH-1];
                            r_mag   <= i_value[DATA_WIDTH-1] ?
                                       (~i_value) + DATA_WIDTH'(1) : i_value;
                            r_cnt   <= CNT_W'(DATA_WIDTH - 1);
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    r_digs <= {n_adj[DIG_BITS-2:0], r_mag[DATA_WIDTH-1]};
                    r_mag  <= {r_mag[DATA_WIDTH-2:0], 1'b0};
                    r_cnt  <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE) || r_done;
    assign o_conv.done = r_done;
    assign o_conv.neg  = r_neg;
    assign o_conv.digs = r_digs;

endmodule

`default_nettype wire

### sv/itad_emit.sv
`default_nettype none

module itad_emit (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  itad_pkg::t_conv   i_conv,
    output logic              o_busy,
    output logic              o_valid,
    output logic [6:0]        o_char_code,
    output logic              o_last
);
    import itad_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state             r_state;
    t_digits            r_digs;
    logic [REM_W-1:0]   r_rem;
    logic               r_neg;
    logic               r_valid;
    logic [6:0]         r_char;
    logic               r_last;
    logic [3:0]         n_top;
    logic [6:0]         n_char;
    logic               n_skip;

    assign n_top  = r_digs[DIG_BITS-1 -: 4];
    assign n_char = (n_top < 4'd10) ? CH_ZERO + 7'(n_top) : CH_ALPHA + 7'(n_top);
    // drop leading zeros, and the oldest digits when the text would overflow
    assign n_skip = ((n_top == 4'd0) && (r_rem > REM_W'(1))) ||
                    (r_rem > REM_W'(MAX_CHARS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_conv.done) begin
                        r_digs  <= i_conv.digs;
                        r_neg   <= i_conv.neg;
                        r_rem   <= REM_W'(NUM_DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (n_skip) begin
                        r_digs <= {r_digs[DIG_BITS-5:0], 4'd0};
                        r_rem  <= r_rem - REM_W'(1);
                    end else if (r_neg && (r_rem < REM_W'(MAX_CHARS))) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_state <= S_DIGIT;
                    end
                end
                S_SIGN: begin
                    r_valid <= 1'b1;
                    r_char  <= CH_MINUS;
                    r_state <= S_DIGIT;
                end
                S_DIGIT: begin
                    r_valid <= 1'b1;
                    r_char  <= n_char;
                    r_last  <= (r_rem == REM_W'(1));
                    r_digs  <= {r_digs[DIG_BITS-5:0], 4'd0};
                    r_rem   <= r_rem - REM_W'(1);
                    if (r_rem == REM_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

`include "integer_to_ascii_digits_unit_defines.svh"

    `ITAD_ASSERT_NOW(a_last_has_valid, r_last, r_valid)
    `ITAD_ASSERT_NOW(a_minus_not_last, r_valid && (r_char == CH_MINUS), !r_last)
    `ITAD_ASSERT_NEXT(a_final_digit_ends, (r_state == S_DIGIT) && (r_rem == REM_W'(1)),
        (r_state == S_IDLE) && r_last)
    `ITAD_ASSERT_NOW(a_rem_in_range, r_state != S_IDLE, r_rem <= REM_W'(NUM_DIGITS))

endmodule

`default_nettype wire

### sv/integer_to_ascii_digits_unit.sv
`default_nettype none

// Converts one 32-bit word to ASCII text, most significant character first, one
// character per o_valid strobe with o_last on the final one. i_action 0 gives signed
// decimal with a leading minus, 1 gives lower-case hex; no leading zeros, zero gives
// "0". A word is taken when i_start is high and o_busy low. Decimal runs a bit-serial
// double dabble over the DATA_WIDTH bits; hex loads the nibbles straight from the word.
// Leading zeros are then dropped one digit per cycle and the text leaves one character
// per cycle. Skipped zeros and emitted digits together always number NUM_DIGITS,
// whatever the value. The next word can be taken on the cycle of the last character.
// Characters cannot be held off: the receiver must take each word on the cycle its
// strobe is high.
module integer_to_ascii_digits_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_action,
    input  wire  [31:0] i_value,
    output logic        o_busy,
    output logic        o_valid,
    output logic [6:0]  o_char_code,
    output logic        o_last
);
    import itad_pkg::*;

    t_conv   w_conv;
    logic    w_conv_busy;
    logic    w_emit_busy;
    t_word   w_value;

    assign w_value = DATA_WIDTH'(i_value);
    assign o_busy  = w_conv_busy || w_emit_busy;

    itad_dabble u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start && !o_busy),
        .i_action (i_action),
        .i_value  (w_value),
        .o_busy   (w_conv_busy),
        .o_conv   (w_conv)
    );

    itad_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_conv      (w_conv),
        .o_busy      (w_emit_busy),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire
